// ===== sv/uu_body_decoder_defines.svh =====
// Assertion macros shared by the uu body decoder RTL.
// No dependencies; include by bare file name.
`ifndef UU_BODY_DECODER_DEFINES_SVH
`define UU_BODY_DECODER_DEFINES_SVH

// expr holds at every clock edge out of reset
`define UUB_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cond at an edge implies expr at the same edge
`define UUB_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// cond at an edge implies expr at the next edge
`define UUB_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== sv/uub_pkg.sv =====
// Types and constants for the uu body decoder.
// No dependencies; used by uub_core, uub_queue and uu_body_decoder.
package uub_pkg;

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_GROUP = 3'd1,
        PH_SKIP  = 3'd2,
        PH_ENDED = 3'd3,
        PH_ERROR = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_END   = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_LOW     = 8'd32;
    localparam logic [7:0] CHAR_HIGH    = 8'd96;
    localparam int MAX_RESULTS = 3;

    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int Q_ROOM  = Q_DEPTH - MAX_RESULTS;

    typedef struct packed {
        logic       last;
        status_t    status;
        logic [7:0] data;
    } result_t;

    typedef struct packed {
        logic [1:0]        n;
        result_t [2:0]     r;
    } push_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               room;
    } queue_status_t;

endpackage

// ===== sv/uub_core.sv =====
// Decode step and line/group state of the uu body decoder.
// Depends on uub_pkg; produces up to three results per request.
module uub_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [7:0]     in_char,
    output uub_pkg::push_t push
);

    uub_pkg::phase_t phase_reg, phase_next;
    logic [5:0] remaining_reg, remaining_next;
    logic [1:0] pos_reg, pos_next;
    logic [5:0] held_reg [3];
    logic [5:0] held_next [3];

    logic [5:0] sextet;
    logic       in_range;

    // (c - 32) mod 64 is a flip of bit 5
    assign sextet   = in_char[5:0] ^ 6'b100000;
    assign in_range = (in_char >= uub_pkg::CHAR_LOW) && (in_char <= uub_pkg::CHAR_HIGH);

    function automatic uub_pkg::result_t mk(logic [7:0] d, uub_pkg::status_t st, logic l);
        uub_pkg::result_t r;
        r.data   = d;
        r.status = st;
        r.last   = l;
        return r;
    endfunction

    // next state
    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        pos_next       = pos_reg;
        held_next      = held_reg;
        if (en) begin
            unique case (phase_reg)
                uub_pkg::PH_COUNT: begin
                    remaining_next = sextet;
                    pos_next       = 2'd0;
                    if (sextet == 6'd0) begin
                        phase_next = uub_pkg::PH_ENDED;
                    end else begin
                        phase_next = uub_pkg::PH_GROUP;
                    end
                end
                uub_pkg::PH_SKIP: begin
                    if (in_char == uub_pkg::CHAR_NEWLINE) begin
                        phase_next = uub_pkg::PH_COUNT;
                    end
                end
                uub_pkg::PH_ENDED: begin
                end
                uub_pkg::PH_GROUP: begin
                    if (!in_range) begin
                        phase_next = uub_pkg::PH_ERROR;
                    end else if (remaining_reg >= 6'd3) begin
                        if (pos_reg != 2'd3) begin
                            held_next[pos_reg] = sextet;
                            pos_next           = pos_reg + 2'd1;
                        end else begin
                            remaining_next = remaining_reg - 6'd3;
                            pos_next       = 2'd0;
                            if (remaining_reg == 6'd3) begin
                                phase_next = uub_pkg::PH_SKIP;
                            end
                        end
                    end else begin
                        // short final group
                        case (pos_reg)
                            2'd0: begin
                                held_next[0] = sextet;
                                pos_next     = 2'd1;
                            end
                            2'd1: begin
                                if (remaining_reg <= 6'd1) begin
                                    remaining_next = 6'd0;
                                    pos_next       = 2'd0;
                                    phase_next     = uub_pkg::PH_SKIP;
                                end else begin
                                    held_next[1] = sextet;
                                    pos_next     = 2'd2;
                                end
                            end
                            default: begin
                                remaining_next = 6'd0;
                                pos_next       = 2'd0;
                                phase_next     = uub_pkg::PH_SKIP;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // results
    always_comb begin
        push.n    = 2'd0;
        push.r[0] = mk(8'd0, uub_pkg::ST_DATA, 1'b1);
        push.r[1] = mk(8'd0, uub_pkg::ST_DATA, 1'b0);
        push.r[2] = mk(8'd0, uub_pkg::ST_DATA, 1'b1);
        if (en) begin
            unique case (phase_reg)
                uub_pkg::PH_COUNT: begin
                    if (sextet == 6'd0) begin
                        push.n    = 2'd1;
                        push.r[0] = mk(8'd0, uub_pkg::ST_END, 1'b1);
                    end
                end
                uub_pkg::PH_SKIP: begin
                end
                uub_pkg::PH_ENDED: begin
                end
                uub_pkg::PH_GROUP: begin
                    if (!in_range) begin
                        push.n    = 2'd1;
                        push.r[0] = mk(8'd0, uub_pkg::ST_RANGE, 1'b1);
                    end else if (remaining_reg >= 6'd3) begin
                        if (pos_reg == 2'd3) begin
                            push.n    = 2'd3;
                            push.r[0] = mk({held_reg[0], held_reg[1][5:4]},
                                           uub_pkg::ST_DATA, 1'b0);
                            push.r[1] = mk({held_reg[1][3:0], held_reg[2][5:2]},
                                           uub_pkg::ST_DATA, 1'b0);
                            push.r[2] = mk({held_reg[2][1:0], sextet},
                                           uub_pkg::ST_DATA, 1'b1);
                        end
                    end else begin
                        case (pos_reg)
                            2'd0: begin
                            end
                            2'd1: begin
                                push.n    = 2'd1;
                                push.r[0] = mk({held_reg[0], sextet[5:4]},
                                               uub_pkg::ST_DATA, 1'b1);
                            end
                            default: begin
                                push.n    = 2'd1;
                                push.r[0] = mk({held_reg[1][3:0], sextet[5:2]},
                                               uub_pkg::ST_DATA, 1'b1);
                            end
                        endcase
                    end
                end
                default: begin
                    push.n    = 2'd1;
                    push.r[0] = mk(8'd0, uub_pkg::ST_RANGE, 1'b1);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= uub_pkg::PH_COUNT;
            remaining_reg <= 6'd0;
            pos_reg       <= 2'd0;
            held_reg[0]   <= 6'd0;
            held_reg[1]   <= 6'd0;
            held_reg[2]   <= 6'd0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            pos_reg       <= pos_next;
            held_reg      <= held_next;
        end
    end

endmodule

// ===== sv/uub_queue.sv =====
// Result queue of the uu body decoder: up to three writes, one read a cycle while out_ready is high.
// Depends on uub_pkg.
module uub_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  uub_pkg::push_t         push,
    output logic                   out_valid,
    input  logic                   out_ready,
    output uub_pkg::result_t       out_item,
    output uub_pkg::queue_status_t qstat
);

    uub_pkg::result_t mem [uub_pkg::Q_DEPTH];

    logic [uub_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [uub_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [uub_pkg::Q_CNT_W-1:0] count_reg, count_next;
    logic                        pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign qstat.count = count_reg;
    assign qstat.room  = (count_reg <= uub_pkg::Q_CNT_W'(uub_pkg::Q_ROOM));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + uub_pkg::Q_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + uub_pkg::Q_PTR_W'(pop);
        count_next  = count_reg + uub_pkg::Q_CNT_W'(push.n) - uub_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_ptr_reg] <= push.r[0];
        end
        if (push.n >= 2'd2) begin
            mem[wr_ptr_reg + uub_pkg::Q_PTR_W'(1)] <= push.r[1];
        end
        if (push.n == 2'd3) begin
            mem[wr_ptr_reg + uub_pkg::Q_PTR_W'(2)] <= push.r[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/uu_body_decoder.sv =====
// Top level of the uu body decoder: input register, decode step, result queue.
// Depends on uub_pkg, uub_core, uub_queue and uu_body_decoder_defines.svh.
//
// Takes one body character per cycle on the slave stream while the decode step
// is not waiting, and gives decoded bytes on the master stream, one request
// per result. Each character is held in an input register and decoded from
// there once the queue has room; a full group of four characters writes its
// three bytes at once into an eight-entry result queue that drains one result
// per cycle while m_tready is high. The decode step waits while fewer than
// three queue entries are free; with the output always ready the block
// sustains one character per cycle. m_tuser carries the status: data, end of
// body, or character out of range (sticky until reset); m_tlast marks the
// final result caused by a character.
`include "uu_body_decoder_defines.svh"

module uu_body_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] status
    output logic       m_tlast    // last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       process;

    uub_pkg::push_t         push;
    uub_pkg::result_t       out_item;
    uub_pkg::queue_status_t qstat;

    assign process  = in_valid_reg && qstat.room;
    assign s_tready = !in_valid_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
    end

    uub_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (process),
        .in_char (in_char_reg),
        .push    (push)
    );

    uub_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item),
        .qstat     (qstat)
    );

    assign m_tdata = out_item.data;
    assign m_tuser = out_item.status;
    assign m_tlast = out_item.last;

    `UUB_ASSERT_ALWAYS(a_queue_bound, aclk, aresetn, qstat.count <= 4'(uub_pkg::Q_DEPTH), "result queue overflow")
    `UUB_ASSERT_NEXT(a_in_capture, aclk, aresetn, s_tvalid && s_tready, in_valid_reg, "accepted request not held in input register")
    `UUB_ASSERT_IMPLY(a_status_last, aclk, aresetn, m_tvalid && (m_tuser != uub_pkg::ST_DATA), m_tlast && (m_tdata == 8'd0), "status result not marked last")
    `UUB_ASSERT_IMPLY(a_status_code, aclk, aresetn, m_tvalid, m_tuser != 2'd3, "unused status code on output")

endmodule
